>>> sv/ptt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptt_pkg: shared types and codes of the periodic timer table
// Beat structs for commands and results, command kinds, result status codes.
// ----------------------------------------------------------------------------
package ptt_pkg;

	localparam int TIMER_SLOTS_DEF = 32;
	localparam int PERIOD_BITS_DEF = 16;

	// command kinds
	localparam logic [1:0] KIND_TICK  = 2'd0;
	localparam logic [1:0] KIND_REG   = 2'd1;
	localparam logic [1:0] KIND_UNREG = 2'd2;

	// result status
	localparam logic [2:0] STAT_FIRED = 3'd0;
	localparam logic [2:0] STAT_REG   = 3'd1;
	localparam logic [2:0] STAT_REJ   = 3'd2;
	localparam logic [2:0] STAT_REM   = 3'd3;
	localparam logic [2:0] STAT_DONE  = 3'd4;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] period;
		logic [7:0]  client_tag;
		logic [4:0]  slot;
	} cmd_t;

	typedef struct packed {
		logic [2:0] status;
		logic [4:0] slot_out;
		logic [7:0] tag_out;
		logic       last;
	} result_t;

endpackage
`default_nettype wire

>>> sv/periodic_timer_table.sv
`timescale 1ns / 1ps
`default_nettype none
// Rejects and unknown kinds give their result in the cycle after the start beat.
// Register: scans up from slot 0 for the lowest free slot, one live bit tested per cycle.
// Unregister: reads the tag, searches the order list, then moves each later entry down.
// Tick: order RAM read, entry RAM read and update per live timer, then a closing beat.
// One command at a time; busy is high until the final beat is issued; results cannot stall.
// Reset clears sequencer, strobe, live mask and live count; the RAMs need no clearing pass.
// ----------------------------------------------------------------------------
// periodic_timer_table: table of periodic software timers
// Registers timers in the lowest free slot, removes them, and on each tick
// walks live timers newest first, firing those whose counter hit the period.
// ----------------------------------------------------------------------------
module periodic_timer_table
	import ptt_pkg::*;
#(
	parameter int TIMER_SLOTS = TIMER_SLOTS_DEF,
	parameter int PERIOD_BITS = PERIOD_BITS_DEF
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    start,
	output      logic    busy,
	input  wire cmd_t    cmd,
	output      logic    strobe,
	output      result_t result
);

	localparam int SLOT_W  = $clog2(TIMER_SLOTS);
	localparam int CNT_W   = $clog2(TIMER_SLOTS + 1);
	localparam int ENTRY_W = 2 * PERIOD_BITS + 8;

	// sequencer states
	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_T_ORD  = 4'd1;  // tick: read order list at ptr
	localparam logic [3:0] S_T_ENT  = 4'd2;  // tick: read entry of that slot
	localparam logic [3:0] S_T_UPD  = 4'd3;  // tick: compare, write back, maybe fire
	localparam logic [3:0] S_T_DONE = 4'd4;  // tick: closing beat
	localparam logic [3:0] S_R_SCAN = 4'd5;  // register: find lowest free slot
	localparam logic [3:0] S_U_TAG  = 4'd6;  // unregister: read entry for its tag
	localparam logic [3:0] S_U_SRCH = 4'd7;  // unregister: read order list at ptr
	localparam logic [3:0] S_U_CMP  = 4'd8;  // unregister: compare with slot
	localparam logic [3:0] S_U_SRD  = 4'd9;  // unregister: read next entry to move
	localparam logic [3:0] S_U_SWR  = 4'd10; // unregister: move it down one place

	logic [3:0]             state_q;
	logic [TIMER_SLOTS-1:0] live_mask_q;
	logic [CNT_W-1:0]       live_count_q;
	logic [SLOT_W-1:0]      ptr_q;     // order position or scan slot
	logic [SLOT_W-1:0]      slot_q;    // slot of the timer being handled
	logic [PERIOD_BITS-1:0] period_q;
	logic [7:0]             tag_q;
	logic                   strobe_q;
	result_t                result_q;

	// RAM ports
	logic                   ent_we;
	logic [SLOT_W-1:0]      ent_waddr;
	logic [ENTRY_W-1:0]     ent_wdata;
	logic [SLOT_W-1:0]      ent_raddr;
	logic [ENTRY_W-1:0]     ent_rdata;
	logic                   ord_we;
	logic [SLOT_W-1:0]      ord_waddr;
	logic [SLOT_W-1:0]      ord_wdata;
	logic [SLOT_W-1:0]      ord_raddr;
	logic [SLOT_W-1:0]      ord_rdata;

	// entry word: {period, counter, tag}
	logic [PERIOD_BITS-1:0] ent_per;
	logic [PERIOD_BITS-1:0] ent_cnt;
	logic [7:0]             ent_tag;
	logic                   ent_hit;

	logic [PERIOD_BITS-1:0] cmd_per;
	logic [SLOT_W-1:0]      cmd_slot;
	logic                   cmd_slot_ok;
	logic                   reg_reject;
	logic [CNT_W-1:0]       ptr_next;  // ptr + 1, counted in live-count width
	logic                   accept;
	logic                   beat_next; // a result beat goes out next cycle

	assign ent_per = ent_rdata[ENTRY_W-1 -: PERIOD_BITS];
	assign ent_cnt = ent_rdata[8 +: PERIOD_BITS];
	assign ent_tag = ent_rdata[7:0];
	assign ent_hit = (ent_cnt == ent_per);

	assign cmd_per     = PERIOD_BITS'(cmd.period);
	assign cmd_slot    = SLOT_W'(cmd.slot);
	// range check first, then the live bit of the in-range slot
	assign cmd_slot_ok = ({2'b00, cmd.slot} < 7'(TIMER_SLOTS)) && live_mask_q[cmd_slot];
	// zero period or full table
	assign reg_reject  = (cmd_per == '0) || (live_count_q == CNT_W'(TIMER_SLOTS));
	assign ptr_next    = CNT_W'(ptr_q) + CNT_W'(1);
	assign accept      = start && (state_q == S_IDLE);

	assign busy   = (state_q != S_IDLE);
	assign strobe = strobe_q;
	assign result = result_q;

	// RAM addressing and writes
	always_comb begin
		ent_we    = 1'b0;
		ent_waddr = slot_q;
		ent_wdata = {ent_per, ent_cnt + PERIOD_BITS'(1), ent_tag};
		ent_raddr = slot_q;
		ord_we    = 1'b0;
		ord_waddr = ptr_q;
		ord_wdata = ord_rdata;
		ord_raddr = ptr_q;
		case (state_q)
			S_T_ENT: begin
				ent_raddr = ord_rdata;
			end
			S_T_UPD: begin
				ent_we = 1'b1;
				if (ent_hit) begin
					ent_wdata = {ent_per, {PERIOD_BITS{1'b0}}, ent_tag};
				end
			end
			S_R_SCAN: begin
				// new timer goes to the end of the oldest-first order list
				ent_waddr = ptr_q;
				ent_wdata = {period_q, {PERIOD_BITS{1'b0}}, tag_q};
				ent_we    = !live_mask_q[ptr_q];
				ord_we    = !live_mask_q[ptr_q];
				ord_waddr = live_count_q[SLOT_W-1:0];
				ord_wdata = ptr_q;
			end
			S_U_SRD: begin
				ord_raddr = ptr_next[SLOT_W-1:0];
			end
			S_U_SWR: begin
				ord_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// result strobe for the next cycle
	always_comb begin
		beat_next = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (cmd.kind)
						KIND_TICK: begin
							beat_next = (live_count_q == '0);
						end
						KIND_REG: begin
							beat_next = reg_reject;
						end
						KIND_UNREG: begin
							beat_next = !cmd_slot_ok;
						end
						default: begin
							beat_next = 1'b1;
						end
					endcase
				end
			end
			S_T_UPD: begin
				beat_next = ent_hit;
			end
			S_T_DONE: begin
				beat_next = 1'b1;
			end
			S_R_SCAN: begin
				beat_next = !live_mask_q[ptr_q];
			end
			S_U_SRD: begin
				beat_next = !(ptr_next < live_count_q);
			end
			default: begin
			end
		endcase
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			live_mask_q  <= '0;
			live_count_q <= '0;
			strobe_q     <= 1'b0;
		end else begin
			strobe_q <= beat_next;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (cmd.kind)
							KIND_TICK: begin
								if (live_count_q != '0) begin
									state_q <= S_T_ORD;
								end
							end
							KIND_REG: begin
								if (!reg_reject) begin
									state_q <= S_R_SCAN;
								end
							end
							KIND_UNREG: begin
								if (cmd_slot_ok) begin
									state_q <= S_U_TAG;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_T_ORD: begin
					state_q <= S_T_ENT;
				end
				S_T_ENT: begin
					state_q <= S_T_UPD;
				end
				S_T_UPD: begin
					state_q <= (ptr_q == '0) ? S_T_DONE : S_T_ORD;
				end
				S_T_DONE: begin
					state_q <= S_IDLE;
				end
				S_R_SCAN: begin
					if (!live_mask_q[ptr_q]) begin
						live_mask_q[ptr_q] <= 1'b1;
						live_count_q       <= live_count_q + CNT_W'(1);
						state_q            <= S_IDLE;
					end
				end
				S_U_TAG: begin
					state_q <= S_U_SRCH;
				end
				S_U_SRCH: begin
					state_q <= S_U_CMP;
				end
				S_U_CMP: begin
					state_q <= (ord_rdata == slot_q) ? S_U_SRD : S_U_SRCH;
				end
				S_U_SRD: begin
					if (ptr_next < live_count_q) begin
						state_q <= S_U_SWR;
					end else begin
						live_mask_q[slot_q] <= 1'b0;
						live_count_q        <= live_count_q - CNT_W'(1);
						state_q             <= S_IDLE;
					end
				end
				S_U_SWR: begin
					state_q <= S_U_SRD;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers and result beat
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				slot_q   <= cmd_slot;
				period_q <= cmd_per;
				tag_q    <= cmd.client_tag;
				// tick walks newest first: order list is stored oldest first
				ptr_q    <= (cmd.kind == KIND_TICK) ?
					SLOT_W'(live_count_q - CNT_W'(1)) : '0;
				result_q.status   <= (cmd.kind == KIND_TICK) ? STAT_DONE : STAT_REJ;
				result_q.slot_out <= (cmd.kind == KIND_UNREG) ? cmd.slot : 5'd0;
				result_q.tag_out  <= 8'd0;
				result_q.last     <= 1'b1;
			end
			S_T_ENT: begin
				slot_q <= ord_rdata;
			end
			S_T_UPD: begin
				result_q.status   <= STAT_FIRED;
				result_q.slot_out <= 5'(slot_q);
				result_q.tag_out  <= ent_tag;
				result_q.last     <= 1'b0;
				ptr_q             <= ptr_q - SLOT_W'(1);
			end
			S_T_DONE: begin
				result_q.status   <= STAT_DONE;
				result_q.slot_out <= 5'd0;
				result_q.tag_out  <= 8'd0;
				result_q.last     <= 1'b1;
			end
			S_R_SCAN: begin
				result_q.status   <= STAT_REG;
				result_q.slot_out <= 5'(ptr_q);
				result_q.tag_out  <= 8'd0;
				result_q.last     <= 1'b1;
				if (live_mask_q[ptr_q]) begin
					ptr_q <= ptr_q + SLOT_W'(1);
				end
			end
			S_U_SRCH: begin
				tag_q <= ent_tag;
			end
			S_U_CMP: begin
				if (ord_rdata != slot_q) begin
					ptr_q <= ptr_q + SLOT_W'(1);
				end
			end
			S_U_SRD: begin
				result_q.status   <= STAT_REM;
				result_q.slot_out <= 5'(slot_q);
				result_q.tag_out  <= tag_q;
				result_q.last     <= 1'b1;
			end
			S_U_SWR: begin
				ptr_q <= ptr_q + SLOT_W'(1);
			end
			default: begin
			end
		endcase
	end

	// period, counter and tag of each slot
	ptt_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TIMER_SLOTS)
	) u_entry_ram (
		.clk  (clk),
		.we   (ent_we),
		.waddr(ent_waddr),
		.wdata(ent_wdata),
		.raddr(ent_raddr),
		.rdata(ent_rdata)
	);

	// slot numbers of live timers, oldest first
	ptt_ram #(
		.WIDTH(SLOT_W),
		.DEPTH(TIMER_SLOTS)
	) u_order_ram (
		.clk  (clk),
		.we   (ord_we),
		.waddr(ord_waddr),
		.wdata(ord_wdata),
		.raddr(ord_raddr),
		.rdata(ord_rdata)
	);

endmodule
`default_nettype wire

>>> sv/ptt_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptt_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module ptt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

>>> sv/ptt_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptt_checker: port-level checks of the periodic timer table
// Watches the command and result ports; bound to the top level.
// ----------------------------------------------------------------------------
module ptt_checker
	import ptt_pkg::*;
(
	input wire logic    clk,
	input wire logic    arst_n,
	input wire logic    start,
	input wire logic    busy,
	input wire logic    strobe,
	input wire result_t result
);

	// only fired beats are non-final
	a_last_vs_fired: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> ((result.status == STAT_FIRED) == !result.last))
		else $error("last flag does not match fired status");

	// a tick still in progress keeps the block busy
	a_busy_mid_tick: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !result.last |-> busy)
		else $error("non-final beat while not busy");

	// busy only rises after a start beat
	a_busy_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose without start");

	// status codes stay in range
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (result.status <= STAT_DONE))
		else $error("status code out of range");

endmodule

bind periodic_timer_table ptt_checker u_ptt_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.strobe(strobe),
	.result(result)
);
`default_nettype wire
